// ===== rtl/core/otm_pkg.sv =====
// shared types for the operator token matcher
package otm_pkg;

  typedef enum logic [5:0] {
    TK_INVALID,
    TK_INC,
    TK_ADD_ASSIGN,
    TK_PLUS,
    TK_ARROW,
    TK_DEC,
    TK_SUB_ASSIGN,
    TK_MINUS,
    TK_MUL_ASSIGN,
    TK_POW_ASSIGN,
    TK_POW,
    TK_STAR,
    TK_DIV_ASSIGN,
    TK_FLOOR_DIV,
    TK_SLASH,
    TK_MOD_ASSIGN,
    TK_PERCENT,
    TK_LOG_AND,
    TK_AND_ASSIGN,
    TK_AMP,
    TK_LOG_OR,
    TK_OR_ASSIGN,
    TK_PIPE,
    TK_XOR_ASSIGN,
    TK_CARET,
    TK_TILDE,
    TK_EQ,
    TK_ASSIGN,
    TK_NE,
    TK_BANG,
    TK_SHL_ASSIGN,
    TK_SHL,
    TK_LE,
    TK_LT,
    TK_SHR_ASSIGN,
    TK_SHR,
    TK_GE,
    TK_GT,
    TK_SCOPE,
    TK_COLON,
    TK_COALESCE,
    TK_QUESTION,
    TK_ELLIPSIS,
    TK_DOT,
    TK_LPAREN,
    TK_RPAREN,
    TK_LBRACE,
    TK_RBRACE,
    TK_LBRACKET,
    TK_RBRACKET,
    TK_SEMI,
    TK_COMMA,
    TK_AT,
    TK_HASH,
    TK_DOLLAR
  } kind_t;

  localparam int unsigned LINE_W  = 24;
  localparam int unsigned COL_W   = 16;
  localparam int unsigned TOTAL_W = 32;

  typedef struct packed {
    logic [7:0] cur_char;
    logic [7:0] next_char;
    logic [7:0] after_char;
  } window_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] len;
  } dec_t;

endpackage

// ===== rtl/core/operator_token_matcher.sv =====
// operator token matcher top level: input register, decode, result register
//
// Takes one character window per cycle and returns one token result per
// window, in order. An accepted transfer is held in the input register, decoded
// by a single level of compare logic, and written to the result register
// together with the running operator count. Throughput is one transfer per
// cycle while the output side takes results; when it stalls, the input
// register still fills before s_axis_tready drops. The count starts at zero
// after rst, counts every non-invalid token and wraps at 2^32.
module operator_token_matcher
  import otm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cur_char, next_char, after_char, start_line, start_column
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // token_kind, consumed, token_line, token_column, op_total
  output logic [79:0] m_axis_tdata
);

  logic               in_valid;
  window_t            in_win;
  logic [LINE_W-1:0]  in_line;
  logic [COL_W-1:0]   in_column;

  logic               out_valid;
  kind_t              out_kind;
  logic [1:0]         out_len;
  logic [LINE_W-1:0]  out_line;
  logic [COL_W-1:0]   out_column;
  logic [TOTAL_W-1:0] tally;
  logic [TOTAL_W-1:0] tally_next;

  dec_t dec;
  logic out_free;
  logic load_out;
  logic take_in;

  assign out_free      = !out_valid || m_axis_tready;
  assign load_out      = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  otm_decode u_decode (
    .win (in_win),
    .dec (dec)
  );

  assign tally_next = (dec.kind != TK_INVALID) ? tally + TOTAL_W'(1) : tally;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      tally     <= '0;
    end else begin
      if (take_in) begin
        in_valid <= 1'b1;
      end else if (load_out) begin
        in_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
        tally     <= tally_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_win.cur_char   <= s_axis_tdata[7:0];
      in_win.next_char  <= s_axis_tdata[15:8];
      in_win.after_char <= s_axis_tdata[23:16];
      in_line           <= s_axis_tdata[47:24];
      in_column         <= s_axis_tdata[63:48];
    end
    if (load_out) begin
      out_kind   <= dec.kind;
      out_len    <= dec.len;
      out_line   <= in_line;
      out_column <= in_column;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {tally, out_column, out_line, out_len, out_kind};

  a_tally_moves_on_load: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && tally != $past(tally)) |-> $past(load_out))
    else $error("operator count changed without a result load");

  a_invalid_len_one: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == TK_INVALID) |-> out_len == 2'd1)
    else $error("invalid token with length other than one");

  a_len_three_kinds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_len == 2'd3) |->
      (out_kind == TK_ARROW || out_kind == TK_POW_ASSIGN ||
       out_kind == TK_SHL_ASSIGN || out_kind == TK_SHR_ASSIGN ||
       out_kind == TK_ELLIPSIS))
    else $error("three character length on a short token kind");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_len != 2'd0)
    else $error("result with zero length");

endmodule

// ===== rtl/core/otm_decode.sv =====
// longest-match decode of one character window into token kind and length
module otm_decode
  import otm_pkg::*;
(
  input  window_t win,
  output dec_t    dec
);

  localparam logic [7:0] CH_PLUS    = "+";
  localparam logic [7:0] CH_MINUS   = "-";
  localparam logic [7:0] CH_STAR    = "*";
  localparam logic [7:0] CH_SLASH   = "/";
  localparam logic [7:0] CH_PERCENT = "%";
  localparam logic [7:0] CH_AMP     = "&";
  localparam logic [7:0] CH_PIPE    = "|";
  localparam logic [7:0] CH_CARET   = "^";
  localparam logic [7:0] CH_TILDE   = "~";
  localparam logic [7:0] CH_EQUAL   = "=";
  localparam logic [7:0] CH_BANG    = "!";
  localparam logic [7:0] CH_LESS    = "<";
  localparam logic [7:0] CH_GREATER = ">";
  localparam logic [7:0] CH_COLON   = ":";
  localparam logic [7:0] CH_QUEST   = "?";
  localparam logic [7:0] CH_DOT     = ".";
  localparam logic [7:0] CH_LPAREN  = "(";
  localparam logic [7:0] CH_RPAREN  = ")";
  localparam logic [7:0] CH_LBRACE  = "{";
  localparam logic [7:0] CH_RBRACE  = "}";
  localparam logic [7:0] CH_LBRACK  = "[";
  localparam logic [7:0] CH_RBRACK  = "]";
  localparam logic [7:0] CH_SEMI    = ";";
  localparam logic [7:0] CH_COMMA   = ",";
  localparam logic [7:0] CH_AT      = "@";
  localparam logic [7:0] CH_HASH    = "#";
  localparam logic [7:0] CH_DOLLAR  = "$";
  localparam logic [7:0] CH_ZERO    = "0";
  localparam logic [7:0] CH_NINE    = "9";

  logic [7:0] c;
  logic [7:0] n;
  logic [7:0] a;

  assign c = win.cur_char;
  assign n = win.next_char;
  assign a = win.after_char;

  always_comb begin
    dec.kind = TK_INVALID;
    dec.len  = 2'd1;
    case (c)
      CH_PLUS: begin
        if (n == CH_PLUS) begin
          dec.kind = TK_INC; dec.len = 2'd2;
        end else if (n == CH_EQUAL) begin
          dec.kind = TK_ADD_ASSIGN; dec.len = 2'd2;
        end else begin
          dec.kind = TK_PLUS;
        end
      end
      CH_MINUS: begin
        if (n == CH_GREATER) begin
          dec.kind = TK_ARROW; dec.len = 2'd2;
        end else if (n == CH_MINUS && a == CH_GREATER) begin
          dec.kind = TK_ARROW; dec.len = 2'd3;
        end else if (n == CH_MINUS) begin
          dec.kind = TK_DEC; dec.len = 2'd2;
        end else if (n == CH_EQUAL) begin
          dec.kind = TK_SUB_ASSIGN; dec.len = 2'd2;
        end else begin
          dec.kind = TK_MINUS;
        end
      end
      CH_STAR: begin
        if (n == CH_EQUAL) begin
          dec.kind = TK_MUL_ASSIGN; dec.len = 2'd2;
        end else if (n == CH_STAR && a == CH_EQUAL) begin
          dec.kind = TK_POW_ASSIGN; dec.len = 2'd3;
        end else if (n == CH_STAR) begin
          dec.kind = TK_POW; dec.len = 2'd2;
        end else begin
          dec.kind = TK_STAR;
        end
      end
      CH_SLASH: begin
        if (n == CH_EQUAL) begin
          dec.kind = TK_DIV_ASSIGN; dec.len = 2'd2;
        end else if (n == CH_SLASH) begin
          dec.kind = TK_FLOOR_DIV; dec.len = 2'd2;
        end else begin
          dec.kind = TK_SLASH;
        end
      end
      CH_PERCENT: begin
        if (n == CH_EQUAL) begin
          dec.kind = TK_MOD_ASSIGN; dec.len = 2'd2;
        end else begin
          dec.kind = TK_PERCENT;
        end
      end
      CH_AMP: begin
        if (n == CH_AMP) begin
          dec.kind = TK_LOG_AND; dec.len = 2'd2;
        end else if (n == CH_EQUAL) begin
          dec.kind = TK_AND_ASSIGN; dec.len = 2'd2;
        end else begin
          dec.kind = TK_AMP;
        end
      end
      CH_PIPE: begin
        if (n == CH_PIPE) begin
          dec.kind = TK_LOG_OR; dec.len = 2'd2;
        end else if (n == CH_EQUAL) begin
          dec.kind = TK_OR_ASSIGN; dec.len = 2'd2;
        end else begin
          dec.kind = TK_PIPE;
        end
      end
      CH_CARET: begin
        if (n == CH_EQUAL) begin
          dec.kind = TK_XOR_ASSIGN; dec.len = 2'd2;
        end else begin
          dec.kind = TK_CARET;
        end
      end
      CH_TILDE: dec.kind = TK_TILDE;
      CH_EQUAL: begin
        if (n == CH_EQUAL) begin
          dec.kind = TK_EQ; dec.len = 2'd2;
        end else if (n == CH_GREATER) begin
          dec.kind = TK_ARROW; dec.len = 2'd2;
        end else begin
          dec.kind = TK_ASSIGN;
        end
      end
      CH_BANG: begin
        if (n == CH_EQUAL) begin
          dec.kind = TK_NE; dec.len = 2'd2;
        end else begin
          dec.kind = TK_BANG;
        end
      end
      CH_LESS: begin
        if (n == CH_LESS && a == CH_EQUAL) begin
          dec.kind = TK_SHL_ASSIGN; dec.len = 2'd3;
        end else if (n == CH_LESS) begin
          dec.kind = TK_SHL; dec.len = 2'd2;
        end else if (n == CH_EQUAL) begin
          dec.kind = TK_LE; dec.len = 2'd2;
        end else begin
          dec.kind = TK_LT;
        end
      end
      CH_GREATER: begin
        if (n == CH_GREATER && a == CH_EQUAL) begin
          dec.kind = TK_SHR_ASSIGN; dec.len = 2'd3;
        end else if (n == CH_GREATER) begin
          dec.kind = TK_SHR; dec.len = 2'd2;
        end else if (n == CH_EQUAL) begin
          dec.kind = TK_GE; dec.len = 2'd2;
        end else begin
          dec.kind = TK_GT;
        end
      end
      CH_COLON: begin
        if (n == CH_COLON) begin
          dec.kind = TK_SCOPE; dec.len = 2'd2;
        end else begin
          dec.kind = TK_COLON;
        end
      end
      CH_QUEST: begin
        if (n == CH_QUEST) begin
          dec.kind = TK_COALESCE; dec.len = 2'd2;
        end else begin
          dec.kind = TK_QUESTION;
        end
      end
      CH_DOT: begin
        if (n == CH_DOT && a == CH_DOT) begin
          dec.kind = TK_ELLIPSIS; dec.len = 2'd3;
        end else if (n inside {[CH_ZERO:CH_NINE]}) begin
          // dot before a digit starts a number, not a token here
          dec.kind = TK_INVALID;
        end else begin
          dec.kind = TK_DOT;
        end
      end
      CH_LPAREN: dec.kind = TK_LPAREN;
      CH_RPAREN: dec.kind = TK_RPAREN;
      CH_LBRACE: dec.kind = TK_LBRACE;
      CH_RBRACE: dec.kind = TK_RBRACE;
      CH_LBRACK: dec.kind = TK_LBRACKET;
      CH_RBRACK: dec.kind = TK_RBRACKET;
      CH_SEMI:   dec.kind = TK_SEMI;
      CH_COMMA:  dec.kind = TK_COMMA;
      CH_AT:     dec.kind = TK_AT;
      CH_HASH:   dec.kind = TK_HASH;
      CH_DOLLAR: dec.kind = TK_DOLLAR;
      default: begin
        dec.kind = TK_INVALID;
        dec.len  = 2'd1;
      end
    endcase
  end

endmodule
